// ===== hdl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the Base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int BYTE_W      = 8;
  localparam int SEXTET_W    = 6;
  localparam int GROUP_W     = 24;
  localparam int COUNT_W     = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;  // '='

  // One complete or final group, bytes left-aligned in bits
  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    logic [COUNT_W-1:0] nbytes;   // 1..3 bytes carried
    logic               last;     // group closes the message
  } b64e_group_t;

  // Map a sextet to its ASCII alphabet character
  function automatic logic [BYTE_W-1:0] b64e_char(input logic [SEXTET_W-1:0] s);
    logic [BYTE_W-1:0] s8;
    s8 = BYTE_W'(s);
    if (s < 6'd26) begin
      return s8 + 8'h41;           // 'A'
    end else if (s < 6'd52) begin
      return s8 + 8'h47;           // 'a' - 26
    end else if (s < 6'd62) begin
      return s8 - 8'h04;           // '0' - 52
    end else if (s == 6'd62) begin
      return 8'h2B;                // '+'
    end else begin
      return 8'h2F;                // '/'
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Accept message bytes, hold up to two, and push whole or final groups.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last,
  input  wire logic              q_full,
  output logic                   push,
  output b64e_group_t            push_group
);

  logic [2*BYTE_W-1:0] held_bytes;
  logic [COUNT_W-1:0]  held_count;
  logic [COUNT_W-1:0]  cnt;
  logic                accept;
  logic                store;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // a pending count of three cannot arise; treat it as two
  assign cnt      = (held_count == 2'd3) ? 2'd2 : held_count;
  assign store    = !in_last && (cnt < 2'd2);
  assign push     = accept && !store;

  always_comb begin
    push_group.last   = in_last;
    push_group.nbytes = cnt + 2'd1;
    case (cnt)
      2'd0:    push_group.bits = {in_byte, 16'h0000};
      2'd1:    push_group.bits = {held_bytes[15:8], in_byte, 8'h00};
      default: push_group.bits = {held_bytes, in_byte};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      held_bytes <= '0;
    end else if (accept) begin
      if (store) begin
        held_count <= cnt + 2'd1;
        if (cnt == 2'd0) begin
          held_bytes <= {in_byte, 8'h00};
        end else begin
          held_bytes <= {held_bytes[15:8], in_byte};
        end
      end else begin
        held_count <= '0;
        held_bytes <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  b64e_group_t      push_group,
  output logic             full,
  input  wire logic        pop,
  output logic             empty,
  output b64e_group_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64e_group_t    mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Walk each queued group, one character per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  b64e_group_t            head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_char,
  output logic                   out_end
);

  logic [1:0]          idx;
  logic                load;
  logic [SEXTET_W-1:0] sextet;
  logic                pad;
  logic [BYTE_W-1:0]   char_next;
  logic                end_next;

  assign load = !q_empty && (!out_valid || out_ready);
  assign pop  = load && (idx == 2'd3);

  always_comb begin
    case (idx)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
    pad       = ((idx == 2'd2) && (head.nbytes == 2'd1)) ||
                ((idx == 2'd3) && (head.nbytes != 2'd3));
    char_next = pad ? PAD_CHAR : b64e_char(sextet);
    end_next  = (idx == 2'd3) && ((head.nbytes != 2'd3) || head.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      out_end  <= end_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/base64_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_encoder_top
// Streaming Base64 encoder (standard alphabet, '=' padding).
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata            | tlast
//  s_axis   | in  | [7:0] data_byte  | last_byte: final message byte
//  m_axis   | out | [7:0] out_char   | end_of_text: final character
//
//  A byte transfers in every cycle while the group queue has room; a byte that
//  only joins the pending group leaves no output. Each complete or final group
//  yields four characters, one per cycle through the output register while
//  the output is not stalled, so the output port sets the rate. The group of
//  a closing byte is written into the queue first; its characters are then
//  registered into the output register from the queue head.
//  rst (synchronous) empties the pending bytes, the queue and the output stage;
//  output stalls back up through the queue to s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_top
  import b64e_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic              s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [BYTE_W-1:0]      m_axis_tdata,   // [7:0] out_char
  output logic                   m_axis_tlast
);

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  b64e_group_t push_group;
  b64e_group_t head;

  // Front end: collect bytes into groups
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_group (push_group)
  );

  // Decouple byte intake from character output
  b64e_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  // Back end: emit four characters per group
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_end   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/b64e_checker.sv =====
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the Base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_checker
  import b64e_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [BYTE_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tlast
);

  logic legal_char;

  assign legal_char = ((m_axis_tdata >= 8'h41) && (m_axis_tdata <= 8'h5A)) ||
                      ((m_axis_tdata >= 8'h61) && (m_axis_tdata <= 8'h7A)) ||
                      ((m_axis_tdata >= 8'h30) && (m_axis_tdata <= 8'h39)) ||
                      (m_axis_tdata == 8'h2B) || (m_axis_tdata == 8'h2F) ||
                      (m_axis_tdata == PAD_CHAR);

  // Stalled output transfer holds its character and flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  // Reset leaves no output pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Every character is from the alphabet or padding
  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> legal_char)
    else $error("illegal output character");

  // A padding character that does not end the text is followed by padding
  a_pad_no_input_dep: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata == PAD_CHAR) && !m_axis_tlast
      |=> !m_axis_tvalid || (m_axis_tdata == PAD_CHAR))
    else $error("padding not followed by padding");

  // Input back-pressure only ever comes from a pending output character
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output pending");

endmodule

bind base64_encoder_top b64e_checker u_b64e_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/tb_base64_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_encoder_top
// Self-checking bench for the streaming Base64 encoder. A short table of
// hand-picked messages runs first, then random messages of mixed length.
// Each byte that transfers in is run through a local encoder, and the
// characters it yields, or a typed row's own, are queued. Every character that transfers out is
// checked against the oldest queued one. Both stream sides idle in random
// bursts, and one long output stall forces the input to back up.
// ----------------------------------------------------------------------------

module tb_base64_encoder_top;
  import b64e_pkg::*;

  localparam int CLK_HALF    = 4;        // 8 ns period
  localparam int CYCLE_LIMIT = 200000;   // far beyond the slowest legal run
  localparam int HOLD_CYCLES = 300;      // long output stall
  localparam int TAIL_CYCLES = 20;       // settle time after the last character

  // Standard alphabet, one byte per sextet value, index 0 leftmost
  localparam logic [0:511] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One encoded character as it should leave the block
  typedef struct packed {
    logic [7:0] code;
    logic       eot;
  } enc_char_t;

  // One row of the directed table; text holds four characters, first in
  // the top byte, and is only meaningful when typed is set
  typedef struct packed {
    logic [7:0]  data;
    logic        is_last;
    logic        typed;
    logic [31:0] text;
  } stim_row_t;

  logic            clk;
  logic            rst;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata;   // [7:0] data_byte
  logic            s_axis_tlast;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [7:0]      m_axis_tdata;   // [7:0] out_char
  logic            m_axis_tlast;

  // Local copy of the encoder state
  logic [15:0]     enc_held;
  logic [1:0]      enc_count;
  enc_char_t       step_chars [0:3];
  int              step_count;

  enc_char_t       encoded_chars [$];
  stim_row_t       dir_rows [$];

  int              err_count;
  int              cycle_count;
  int              bytes_sent;
  int              hold_request;
  bit              snd_idle_on;
  bit              rcv_idle_on;

  base64_encoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Stop a hung run; the limit is many times the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Local encoder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
    return ALPHABET[s * 8 +: 8];
  endfunction

  // Advance the local state by one byte and leave its characters in
  // step_chars; step_count says how many there are (zero or four)
  function automatic void encode_byte(input logic [7:0] b, input logic is_last);
    logic [23:0] grp;
    int          nb;
    grp = '0;
    nb  = 0;
    // Hold the byte while the group is still open
    if (!is_last && enc_count < 2'd2) begin
      if (enc_count == 2'd0) begin
        enc_held = {b, 8'h00};
      end else begin
        enc_held[7:0] = b;
      end
      enc_count  = enc_count + 2'd1;
      step_count = 0;
      return;
    end
    // Left-align the bytes of the closing group
    case (enc_count)
      2'd0: begin
        grp = {b, 16'h0000};
        nb  = 1;
      end
      2'd1: begin
        grp = {enc_held[15:8], b, 8'h00};
        nb  = 2;
      end
      default: begin
        grp = {enc_held, b};
        nb  = 3;
      end
    endcase
    step_chars[0] = '{code: sextet_ascii(grp[23:18]), eot: 1'b0};
    step_chars[1] = '{code: sextet_ascii(grp[17:12]), eot: 1'b0};
    step_chars[2] = '{code: (nb >= 2) ? sextet_ascii(grp[11:6]) : PAD_CHAR, eot: 1'b0};
    if (nb == 3) begin
      step_chars[3] = '{code: sextet_ascii(grp[5:0]), eot: is_last};
    end else begin
      step_chars[3] = '{code: PAD_CHAR, eot: 1'b1};
    end
    enc_held   = '0;
    enc_count  = '0;
    step_count = 4;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one byte, wait for its transfer, then queue what it should yield.
  // A typed row queues its hand-written characters in place of the local
  // encoder's, while the local state still advances.
  task automatic send_byte(input logic [7:0] b, input logic is_last,
                           input logic typed, input logic [31:0] text);
    int burst;
    if (snd_idle_on && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (burst) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    encode_byte(b, is_last);
    for (int k = 0; k < step_count; k++) begin
      if (typed) begin
        encoded_chars.push_back('{code: text[31 - 8 * k -: 8],
                                  eot: (k == 3) && is_last});
      end else begin
        encoded_chars.push_back(step_chars[k]);
      end
    end
  endtask

  // Lean toward the extremes so the all-zero and all-one sextets show up
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1, 1'b0, 32'h0);
    end
  endtask

  // Mostly short messages, now and then a long run of full groups
  function automatic int pick_length();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  task automatic send_random(input int target);
    while (bytes_sent < target) begin
      send_message(pick_length());
    end
  endtask

  // Pause the input until every queued character has come out
  task automatic drain_output();
    while (encoded_chars.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [7:0] b, input logic is_last,
                                  input logic typed, input logic [31:0] text);
    dir_rows.push_back('{data: b, is_last: is_last, typed: typed, text: text});
  endfunction

  // --------------------------------------------------------------------------
  // Output side: ready pattern, with the long hold counted here
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    int n;
    m_axis_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rcv_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each output transfer against the oldest queued character
  always @(posedge clk) begin
    enc_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (encoded_chars.size() == 0) begin
        $error("out_char: no character expected, got %h (end_of_text %b)",
               m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        want = encoded_chars.pop_front();
        if (m_axis_tdata !== want.code) begin
          $error("out_char: expected %h, got %h", want.code, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want.eot) begin
          $error("end_of_text: expected %b, got %b", want.eot, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    enc_held      = '0;
    enc_count     = '0;
    step_count    = 0;
    err_count     = 0;
    cycle_count   = 0;
    bytes_sent    = 0;
    hold_request  = 0;
    snd_idle_on   = 1'b0;
    rcv_idle_on   = 1'b1;

    // Directed table: extremes, both pad lengths, full groups, a message
    // that spans more than one group
    add_row(8'h00, 1'b1, 1'b1, "AA==");   // lone zero byte right after reset
    add_row(8'hFF, 1'b1, 1'b1, "/w==");   // lone all-ones byte
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b1, 1'b1, "AAA=");   // two bytes, single pad
    add_row(8'hFF, 1'b0, 1'b0, 32'h0);
    add_row(8'hFF, 1'b1, 1'b1, "//8=");
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b0, 1'b1, "AAAA");   // full group, message goes on
    add_row(8'hFF, 1'b0, 1'b0, 32'h0);
    add_row(8'hFF, 1'b0, 1'b0, 32'h0);
    add_row(8'hFF, 1'b1, 1'b1, "////");   // full group closes the message
    add_row(8'h4D, 1'b0, 1'b0, 32'h0);
    add_row(8'h61, 1'b0, 1'b0, 32'h0);
    add_row(8'h6E, 1'b1, 1'b1, "TWFu");
    add_row(8'h4D, 1'b1, 1'b1, "TQ==");
    add_row(8'h4D, 1'b0, 1'b0, 32'h0);
    add_row(8'h61, 1'b1, 1'b1, "TWE=");
    add_row(8'h80, 1'b0, 1'b0, 32'h0);    // four bytes: group plus one left over
    add_row(8'h7F, 1'b0, 1'b0, 32'h0);
    add_row(8'h01, 1'b0, 1'b0, 32'h0);
    add_row(8'hFE, 1'b1, 1'b0, 32'h0);

    // Hold reset, then release it once
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].is_last, dir_rows[i].typed,
                dir_rows[i].text);
    end

    // Stop offering until the directed characters have all come out
    s_axis_tvalid <= 1'b0;
    drain_output();

    // Random messages with both sides idling
    snd_idle_on = 1'b1;
    send_random(170);

    // Stall the output for a long stretch while bytes keep coming, so the
    // group queue fills and the input backs up
    snd_idle_on  = 1'b0;
    hold_request = HOLD_CYCLES;
    send_message(45);
    snd_idle_on = 1'b1;

    send_random(270);

    // Final stretch at full rate on both sides
    snd_idle_on = 1'b0;
    rcv_idle_on = 1'b0;
    send_random(330);

    // Drop valid and let every queued character come out
    s_axis_tvalid <= 1'b0;
    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_encoder_top.sv
hdl/b64e_checker.sv
verif/tb_base64_encoder_top.sv
